[rtl/lfr_pkg.sv]
package lfr_pkg;

  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned CFG_W        = 21;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned MAX_BINS_DEF = 64;
  localparam int unsigned LANES        = 4;

  localparam logic [CFG_W-1:0] FACTOR_RST = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RECIP_RST  = CFG_W'(65536);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FACTOR = 2'd0,
    CFG_RECIP  = 2'd1,
    CFG_PAIR   = 2'd2
  } lfr_cfg_idx_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_LIMIT = 6'b000010,
    ST_POS   = 6'b000100,
    ST_READ  = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_SUM   = 6'b100000
  } lfr_state_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] first_re;
    logic signed [SAMPLE_BITS-1:0] first_im;
    logic signed [SAMPLE_BITS-1:0] second_re;
    logic signed [SAMPLE_BITS-1:0] second_im;
    logic                          frame_end;
  } lfr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic                          written;
    logic                          run_end;
  } lfr_out_t;

  // Per-lane strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic mul_en;
  } lfr_lane_ctrl_t;

  // Selection flags for the merging stage
  typedef struct packed {
    logic act;
    logic ok;
    logic pair;
    logic last;
  } lfr_sel_t;

endpackage

[rtl/lfr_lane.sv]
module lfr_lane import lfr_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF,
  localparam int unsigned AW = $clog2(MAX_BINS)
) (
  input  logic                          clk_i,
  input  lfr_lane_ctrl_t                ctrl_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic signed [SAMPLE_BITS-1:0] wr_data_i,
  input  logic [AW-1:0]                 rd_addr0_i,
  input  logic [AW-1:0]                 rd_addr1_i,
  input  logic [FRAC_BITS-1:0]          frac_i,
  output logic signed [SAMPLE_BITS-1:0] res_o
);

  localparam int unsigned PW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] RoundC = PW'(1) << (FRAC_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] mem_q [MAX_BINS];
  logic signed [SAMPLE_BITS-1:0] rd0_q, rd1_q;
  logic signed [PW-1:0]          prod0_q, prod1_q;
  logic [FRAC_BITS:0]            wgt0, wgt1;
  logic signed [PW-1:0]          sum;

  // Weights: lower neighbor gets 1 - f, upper neighbor gets f
  assign wgt0 = (FRAC_BITS+1)'(1) << FRAC_BITS;
  assign wgt1 = {1'b0, frac_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd0_q <= mem_q[rd_addr0_i];
      rd1_q <= mem_q[rd_addr1_i];
    end
    if (ctrl_i.mul_en) begin
      prod0_q <= PW'(rd0_q) * PW'($signed({1'b0, wgt0 - wgt1}));
      prod1_q <= PW'(rd1_q) * PW'($signed({1'b0, wgt1}));
    end
  end

  // Round half up, then floor shift back to sample scale
  assign sum   = prod0_q + prod1_q + RoundC;
  assign res_o = sum[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];

endmodule

[rtl/lfr_merge.sv]
module lfr_merge import lfr_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  lfr_sel_t                      sel_i,
  input  logic signed [SAMPLE_BITS-1:0] a_re_i,
  input  logic signed [SAMPLE_BITS-1:0] a_im_i,
  input  logic signed [SAMPLE_BITS-1:0] b_re_i,
  input  logic signed [SAMPLE_BITS-1:0] b_im_i,
  output logic                          free_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output lfr_out_t                      out_data_o
);

  logic                        valid_q;
  lfr_out_t                    data_q, data_d;
  logic signed [SAMPLE_BITS:0] avg_re, avg_im;
  logic                        use_val;

  assign avg_re  = {a_re_i[SAMPLE_BITS-1], a_re_i} + {b_re_i[SAMPLE_BITS-1], b_re_i};
  assign avg_im  = {a_im_i[SAMPLE_BITS-1], a_im_i} + {b_im_i[SAMPLE_BITS-1], b_im_i};
  assign use_val = sel_i.act & sel_i.ok;

  always_comb begin
    data_d = '0;
    if (use_val) begin
      if (sel_i.pair) begin
        data_d.out_re = avg_re[SAMPLE_BITS:1];
        data_d.out_im = avg_im[SAMPLE_BITS:1];
      end else begin
        data_d.out_re = a_re_i;
        data_d.out_im = a_im_i;
      end
    end
    data_d.written = sel_i.pair | use_val;
    data_d.run_end = sel_i.last;
  end

  assign free_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/linear_frame_resampler_core.sv]
// Linear frame resampler.
// Input channel (in_valid_i / in_ready_o / in_data_i): one word per bin; both
// frames travel side by side. Words are stored at one per cycle until a word
// with frame_end set arrives; words beyond MAX_BINS are dropped. in_ready_o is
// high only while loading.
// After frame_end the block computes the output count L once (ST_LIMIT), then
// emits N words, one per loaded bin, on out_valid_o / out_ready_i / out_data_o.
// Each output word passes four steps: position multiply, two-port read of the
// four lane memories, weight multiply, round and merge. out_valid_o rises after
// the ST_LIMIT, ST_POS, ST_READ, ST_MUL and ST_SUM states that follow the edge
// that takes the frame_end word; words do not overlap in the sequencer.
// A stalled receiver holds the finished word in the output register; the
// sequencer waits at the round/merge step until that register frees up. The
// last word of a frame may still wait there while the next frame loads.
// Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) is
// always ready; write it only while no frame is in flight.
// Reset clears the fill count and sequencer and loads factor = recip = 1.0,
// single mode. The sample memories need no clearing pass.
module linear_frame_resampler_core import lfr_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lfr_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lfr_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(MAX_BINS);
  localparam int unsigned CW   = $clog2(MAX_BINS + 1);
  localparam int unsigned PosW = AW + CFG_W;
  localparam int unsigned IntW = PosW - FRAC_BITS;
  localparam int unsigned NW   = IntW + 1;
  localparam int unsigned LW   = CW + CFG_W + 1;
  localparam int unsigned MW   = LW - FRAC_BITS;

  // Configuration registers
  logic [CFG_W-1:0] factor_q, recip_q;
  logic             pair_q;

  // Sequencer
  lfr_state_e       state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    lim_q, lim_d;
  logic [AW-1:0]    m_q, m_d;
  logic [PosW-1:0]  pos_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic             ok_q, act_q, last_q;

  logic             in_fire, has_room;
  logic [CW+CFG_W-1:0] mprod;
  logic [LW-1:0]    msum;
  logic [MW-1:0]    mrnd;
  logic [IntW-1:0]  n0;
  logic [FRAC_BITS-1:0] frac;
  logic [NW-1:0]    n0_ext, n_ext;
  logic             skip;
  logic [AW-1:0]    rd_addr0, rd_addr1;

  lfr_lane_ctrl_t   lane_ctrl;
  lfr_sel_t         sel;
  logic             merge_free, merge_load;
  logic signed [SAMPLE_BITS-1:0] lane_wr [LANES];
  logic signed [SAMPLE_BITS-1:0] lane_res [LANES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RST;
      recip_q  <= RECIP_RST;
      pair_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FACTOR: factor_q <= cfg_data_i;
        CFG_RECIP:  recip_q  <= cfg_data_i;
        CFG_PAIR:   pair_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i & in_ready_o;
  assign has_room   = (fill_q < CW'(MAX_BINS));

  // Output count: round half up of N * factor, capped at N
  assign mprod = (CW+CFG_W)'(n_q) * (CW+CFG_W)'(factor_q);
  assign msum  = {1'b0, mprod} + (LW'(1) << (FRAC_BITS - 1));
  assign mrnd  = msum[LW-1:FRAC_BITS];

  // Source position split into bin index and fraction
  assign n0     = pos_q[PosW-1:FRAC_BITS];
  assign frac   = pos_q[FRAC_BITS-1:0];
  assign n0_ext = NW'(n0);
  assign n_ext  = NW'(n_q);
  // Skip when the bin, or the upper neighbor a fraction needs, lies past the frame
  assign skip   = (n0_ext >= n_ext) || ((frac != '0) && (n0_ext + NW'(1) >= n_ext));
  assign rd_addr0 = n0[AW-1:0];
  assign rd_addr1 = (frac == '0) ? rd_addr0 : AW'(n0_ext + NW'(1));

  assign merge_load = (state_q == ST_SUM) & merge_free;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    n_d     = n_q;
    lim_d   = lim_q;
    m_d     = m_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (has_room) begin
            fill_d = fill_q + CW'(1);
          end
          if (in_data_i.frame_end) begin
            n_d     = has_room ? fill_q + CW'(1) : fill_q;
            fill_d  = '0;
            state_d = ST_LIMIT;
          end
        end
      end
      ST_LIMIT: begin
        lim_d   = (mrnd < MW'(n_q)) ? CW'(mrnd) : n_q;
        m_d     = '0;
        state_d = ST_POS;
      end
      ST_POS:  state_d = ST_READ;
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM: begin
        // Hold until the output register can take the word
        if (merge_free) begin
          if (last_q) begin
            state_d = ST_LOAD;
          end else begin
            m_d     = m_q + AW'(1);
            state_d = ST_POS;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      n_q     <= '0;
      lim_q   <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      n_q     <= n_d;
      lim_q   <= lim_d;
      m_q     <= m_d;
    end
  end

  // Per-position datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_POS) begin
      pos_q <= PosW'(m_q) * PosW'(recip_q);
    end
    if (state_q == ST_READ) begin
      frac_q <= frac;
      ok_q   <= ~skip;
      act_q  <= (CW'(m_q) < lim_q);
      last_q <= (CW'(m_q) == n_q - CW'(1));
    end
  end

  assign lane_ctrl.wr_en  = in_fire & has_room;
  assign lane_ctrl.rd_en  = (state_q == ST_READ);
  assign lane_ctrl.mul_en = (state_q == ST_MUL);

  assign lane_wr[0] = in_data_i.first_re;
  assign lane_wr[1] = in_data_i.first_im;
  assign lane_wr[2] = in_data_i.second_re;
  assign lane_wr[3] = in_data_i.second_im;

  // One lane per component: first re/im, second re/im
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lfr_lane #(
      .MAX_BINS (MAX_BINS)
    ) u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (lane_ctrl),
      .wr_addr_i  (fill_q[AW-1:0]),
      .wr_data_i  (lane_wr[g]),
      .rd_addr0_i (rd_addr0),
      .rd_addr1_i (rd_addr1),
      .frac_i     (frac_q),
      .res_o      (lane_res[g])
    );
  end

  assign sel.act  = act_q;
  assign sel.ok   = ok_q;
  assign sel.pair = pair_q;
  assign sel.last = last_q;

  lfr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .sel_i       (sel),
    .a_re_i      (lane_res[0]),
    .a_im_i      (lane_res[1]),
    .b_re_i      (lane_res[2]),
    .b_im_i      (lane_res[3]),
    .free_o      (merge_free),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_BINS))
    else $error("fill count past store depth");

  // While emitting, the index stays inside the frame and the limit within N
  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POS || state_q == ST_READ || state_q == ST_MUL || state_q == ST_SUM)
    |-> (CW'(m_q) < n_q) && (lim_q <= n_q))
    else $error("emit index or limit out of frame");

  // Pair mode marks every word as written
  a_pair_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_load && pair_q |=> out_valid_o && out_data_o.written)
    else $error("pair mode word not marked written");

  // Input is refused while a frame is being emitted
  a_no_load_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.frame_end |=> !in_ready_o)
    else $error("input taken during emission");

endmodule

[tb/sv/tb_linear_frame_resampler_core.sv]
`timescale 1ns / 1ps

module tb_linear_frame_resampler_core;
  import lfr_pkg::*;

  localparam int unsigned MAX_BINS     = MAX_BINS_DEF;
  localparam int unsigned TOTAL_ITEMS  = 433;      // directed part plus about 410 random
  localparam int unsigned PHASE_ITEMS  = 40;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = 24'sh800000;

  // Expected-result tracker: mirrors the bin stores, the fill count and the
  // three registers, and queues the output words that each frame must emit.
  class resample_scoreboard;
    longint           first_re[MAX_BINS];
    longint           first_im[MAX_BINS];
    longint           second_re[MAX_BINS];
    longint           second_im[MAX_BINS];
    int unsigned      fill;
    logic [CFG_W-1:0] factor;
    logic [CFG_W-1:0] recip;
    logic             pair;
    lfr_out_t         expected_q[$];
    int unsigned      errors;

    function new();
      fill   = 0;
      factor = FACTOR_RST;
      recip  = RECIP_RST;
      pair   = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(lfr_cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_FACTOR: factor = value;
        CFG_RECIP:  recip  = value;
        CFG_PAIR:   pair   = value[0];
        default: ;
      endcase
    endfunction

    function void report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    // Linear blend of bins floor(pos) and floor(pos)+1; ok drops when the
    // position or its upper neighbor lies past the frame.
    function void blend(bit sec, int unsigned n, longint unsigned pos,
                        output bit ok, output longint re, output longint im);
      longint unsigned n0;
      longint          f;
      longint          y0r, y0i, y1r, y1i;
      n0 = pos >> FRAC_BITS;
      f  = longint'(pos & 64'hFFFF);
      ok = 1'b0;
      re = 0;
      im = 0;
      if (n0 >= n) return;
      y0r = sec ? second_re[n0] : first_re[n0];
      y0i = sec ? second_im[n0] : first_im[n0];
      if (f == 0) begin
        ok = 1'b1;
        re = y0r;
        im = y0i;
        return;
      end
      if (n0 + 1 >= n) return;
      y1r = sec ? second_re[n0 + 1] : first_re[n0 + 1];
      y1i = sec ? second_im[n0 + 1] : first_im[n0 + 1];
      re  = (y0r * (65536 - f) + y1r * f + 32768) >>> FRAC_BITS;
      im  = (y0i * (65536 - f) + y1i * f + 32768) >>> FRAC_BITS;
      ok  = 1'b1;
    endfunction

    function void note_input(lfr_in_t w);
      int unsigned     n, lim;
      longint unsigned rounded, pos;
      longint          a_re, a_im, b_re, b_im;
      bit              ok_a, ok_b, wr;
      lfr_out_t        e;
      if (fill < MAX_BINS) begin
        first_re[fill]  = longint'(w.first_re);
        first_im[fill]  = longint'(w.first_im);
        second_re[fill] = longint'(w.second_re);
        second_im[fill] = longint'(w.second_im);
        fill++;
      end
      if (!w.frame_end) return;
      n       = fill;
      fill    = 0;
      rounded = (longint'(n) * factor + 32768) >> FRAC_BITS;
      lim     = (rounded < n) ? int'(rounded) : n;
      for (int unsigned m = 0; m < n; m++) begin
        a_re = 0;
        a_im = 0;
        b_re = 0;
        b_im = 0;
        wr   = 1'b0;
        if (m < lim) begin
          pos = longint'(m) * recip;
          blend(1'b0, n, pos, ok_a, a_re, a_im);
          if (pair) blend(1'b1, n, pos, ok_b, b_re, b_im);
          else wr = ok_a;
        end
        if (pair) begin
          a_re = (a_re + b_re) >>> 1;
          a_im = (a_im + b_im) >>> 1;
          wr   = 1'b1;
        end
        e.out_re  = a_re[SAMPLE_BITS-1:0];
        e.out_im  = a_im[SAMPLE_BITS-1:0];
        e.written = wr;
        e.run_end = (m + 1 == n);
        expected_q.push_back(e);
      end
    endfunction

    function void check_result(lfr_out_t r);
      lfr_out_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: re %0d im %0d",
                                  r.out_re, r.out_im));
        return;
      end
      e = expected_q.pop_front();
      if (r.out_re !== e.out_re)
        report_mismatch($sformatf("out_re got %0d, expected %0d", r.out_re, e.out_re));
      if (r.out_im !== e.out_im)
        report_mismatch($sformatf("out_im got %0d, expected %0d", r.out_im, e.out_im));
      if (r.written !== e.written)
        report_mismatch($sformatf("written got %0b, expected %0b", r.written, e.written));
      if (r.run_end !== e.run_end)
        report_mismatch($sformatf("run_end got %0b, expected %0b", r.run_end, e.run_end));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // Clock, reset and block ports; every input starts at a known value.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready_o;
  lfr_in_t          in_data     = '0;
  logic             out_valid_o;
  logic             out_ready   = 1'b0;
  lfr_out_t         out_data_o;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready_o;
  lfr_cfg_idx_e     cfg_index   = CFG_FACTOR;
  logic [CFG_W-1:0] cfg_data    = '0;

  resample_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned send_idle  = 0;
  int unsigned recv_idle  = 0;
  int unsigned cycle_count = 0;

  linear_frame_resampler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stall the receiver at the current idle rate; zero means always ready.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watch all three channels at the clock edge. Values read here are the
  // ones the block saw at that same edge, so the order of processes within
  // the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready_o) sb.note_input(in_data);
      if (out_valid_o && out_ready) sb.check_result(out_data_o);
    end
  end

  function automatic lfr_in_t mk_word(logic signed [SAMPLE_BITS-1:0] re0,
                                      logic signed [SAMPLE_BITS-1:0] im0,
                                      logic signed [SAMPLE_BITS-1:0] re1,
                                      logic signed [SAMPLE_BITS-1:0] im1,
                                      logic last);
    lfr_in_t w;
    w.first_re  = re0;
    w.first_im  = im0;
    w.second_re = re1;
    w.second_im = im1;
    w.frame_end = last;
    return w;
  endfunction

  // Favor full-scale and near-zero samples, otherwise any 24-bit pattern.
  function automatic logic signed [SAMPLE_BITS-1:0] gen_sample();
    case ($urandom_range(7))
      0:       return SMAX;
      1:       return SMIN;
      2:       return SAMPLE_BITS'($signed($urandom_range(15)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Pick a register value: range ends, unity, zero and the 21-bit maximum
  // show up often; the rest is spread over the nominal range.
  function automatic logic [CFG_W-1:0] gen_reg();
    case ($urandom_range(11))
      0:       return CFG_W'(4096);
      1:       return CFG_W'(1048576);
      2:       return CFG_W'(65536);
      3:       return '0;
      4:       return '1;
      default: return CFG_W'($urandom_range(4096, 1048576));
    endcase
  endfunction

  // Hold valid and the word until the block takes it. Gaps come first, so
  // valid only drops between words, never while one is offered.
  task automatic send_word(lfr_in_t w);
    if (items_sent < TOTAL_ITEMS / 3) begin
      send_idle = 28;
      recv_idle = 71;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle = 71;
      recv_idle = 28;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_word(mk_word(gen_sample(), gen_sample(), gen_sample(), gen_sample(),
                        i == len - 1));
  endtask

  // Leave valid high across back-to-back writes; the caller drops it.
  task automatic cfg_write(lfr_cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Drain every expected word, then give the sequencer time to settle back
  // into loading before anything is reprogrammed. Step past the current edge
  // first so the monitor has noted the word taken at that edge.
  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Drop input valid so the last word is not offered again while idle.
  task automatic apply_setting(logic [CFG_W-1:0] factor, logic [CFG_W-1:0] recip,
                               logic pair);
    in_valid <= 1'b0;
    wait_idle();
    cfg_write(CFG_FACTOR, factor);
    cfg_write(CFG_RECIP, recip);
    cfg_write(CFG_PAIR, CFG_W'(pair));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      phase_start;
    int unsigned      len;
    logic [CFG_W-1:0] factor, recip;
    longint unsigned  inv;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unity factor, single mode: each bin passes straight through,
    // full-scale values on every lane.
    apply_setting(CFG_W'(65536), CFG_W'(65536), 1'b0);
    send_word(mk_word(SMAX, SMIN, SMIN, SMAX, 1'b0));
    send_word(mk_word(SMIN, SMAX, SMAX, SMIN, 1'b0));
    send_word(mk_word('0, -24'sd1, 24'sd1, '0, 1'b0));
    send_word(mk_word(-24'sd1, 24'sd1, '0, -24'sd1, 1'b1));

    // Upsample by two: half-bin positions blend opposite full-scale bins.
    apply_setting(CFG_W'(131072), CFG_W'(32768), 1'b0);
    send_word(mk_word(SMAX, SMIN, SMAX, SMIN, 1'b0));
    send_word(mk_word(SMIN, SMAX, SMIN, SMAX, 1'b0));
    send_word(mk_word(SMAX, SMAX, SMIN, SMIN, 1'b0));
    send_word(mk_word(-24'sd1, -24'sd1, 24'sd1, 24'sd1, 1'b0));
    send_word(mk_word(SMIN, SMIN, SMAX, SMAX, 1'b1));

    // Factor 0.75, step 1.5: the upper neighbor falls past the frame for
    // one index and the last index lies above the output count.
    apply_setting(CFG_W'(49152), CFG_W'(98304), 1'b0);
    send_word(mk_word(24'sd1000, -24'sd1000, SMAX, SMIN, 1'b0));
    send_word(mk_word(SMAX, SMIN, SMIN, SMAX, 1'b0));
    send_word(mk_word(-24'sd3, 24'sd7, 24'sd5, -24'sd9, 1'b0));
    send_word(mk_word(SMIN, SMAX, -24'sd1, 24'sd1, 1'b0));
    send_word(mk_word(24'sd77, -24'sd77, SMAX, SMAX, 1'b1));

    // Same positions in pair mode: skipped entries count as zero and the
    // average is written everywhere.
    apply_setting(CFG_W'(49152), CFG_W'(98304), 1'b1);
    send_word(mk_word(SMAX, SMAX, SMAX, SMAX, 1'b0));
    send_word(mk_word(SMIN, SMIN, SMIN, SMIN, 1'b0));
    send_word(mk_word(-24'sd1, 24'sd1, -24'sd2, 24'sd2, 1'b0));
    send_word(mk_word(SMAX, SMIN, -24'sd1, 24'sd0, 1'b0));
    send_word(mk_word(-24'sd5, 24'sd6, SMIN, SMAX, 1'b1));

    // Zero factor: no index is interpolated; one-bin frame in pair mode.
    apply_setting('0, '0, 1'b1);
    send_word(mk_word(SMAX, SMIN, SMIN, SMAX, 1'b1));

    // Zero step with the widest factor: every index reads bin 0.
    apply_setting('1, '0, 1'b0);
    send_word(mk_word(SMIN, SMAX, SMAX, SMIN, 1'b0));
    send_word(mk_word(24'sd12, -24'sd12, '0, '0, 1'b0));
    send_word(mk_word(SMAX, SMAX, SMIN, SMIN, 1'b1));

    // Random phases. Most settings pair a factor with its matching
    // reciprocal so positions stay inside the frame; the rest are loose.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase == 0) begin
        factor = CFG_W'(4096);
        recip  = CFG_W'(1048576);
      end else if (phase == 1) begin
        factor = CFG_W'(1048576);
        recip  = CFG_W'(4096);
      end else begin
        factor = gen_reg();
        if (factor != 0 && $urandom_range(9) < 7) begin
          inv   = ((64'd1 << 32) + factor / 2) / factor;
          recip = (inv > 64'h1FFFFF) ? '1 : CFG_W'(inv);
        end else begin
          recip = gen_reg();
        end
      end
      apply_setting(factor, recip, 1'($urandom_range(1)));
      phase_start = items_sent;
      // Overrun the bin store once; the extra bins must be dropped.
      if (phase == 3) send_frame(MAX_BINS + $urandom_range(1, 8));
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < TOTAL_ITEMS) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(33, MAX_BINS)
                                        : $urandom_range(1, 16);
        send_frame(len);
      end
      phase++;
    end
    in_valid <= 1'b0;

    wait_idle();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
